FILE: hw/rtl/est_pkg.sv
package est_pkg;

  localparam int CountW  = 32;
  localparam int DriveW  = 8;
  localparam int MagW    = 7;
  localparam int WideW   = 16;
  localparam int RemW    = CountW + 2;
  localparam int NumRegs = 8;
  localparam int AddrW   = $clog2(NumRegs) + 2;
  localparam int InDataW  = 72;
  localparam int OutDataW = 56;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_WAIT = 2'd1,
    PH_TURN = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef struct packed {
    logic             turn_left;
    logic [WideW-1:0] target_turn;
    logic [MagW-1:0]  max_drive;
    logic [MagW-1:0]  approach_drive;
    logic [WideW-1:0] appr_win;
    logic [WideW-1:0] tolerance;
    logic [WideW-1:0] brake_len;
    logic             use_starter;
  } cfg_t;

endpackage

FILE: hw/rtl/est_cfg.sv
module est_cfg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [est_pkg::AddrW-1:0] cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready,
  output est_pkg::cfg_t            cfg
);
  import est_pkg::*;

  typedef enum logic [AddrW-3:0] {
    REG_TURN_LEFT       = 3'd0,
    REG_TARGET_TURN     = 3'd1,
    REG_MAX_DRIVE       = 3'd2,
    REG_APPROACH_DRIVE  = 3'd3,
    REG_APPR_WIN        = 3'd4,
    REG_TOLERANCE       = 3'd5,
    REG_BRAKE_LEN       = 3'd6,
    REG_USE_STARTER     = 3'd7
  } reg_idx_t;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[AddrW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.turn_left       <= 1'b1;
      cfg_r.target_turn     <= '0;
      cfg_r.max_drive       <= '0;
      cfg_r.approach_drive  <= '0;
      cfg_r.appr_win        <= '0;
      cfg_r.tolerance       <= '0;
      cfg_r.brake_len       <= '0;
      cfg_r.use_starter     <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_TURN_LEFT:       cfg_r.turn_left       <= cfg_pwdata[0];
        REG_TARGET_TURN:     cfg_r.target_turn     <= cfg_pwdata[WideW-1:0];
        REG_MAX_DRIVE:       cfg_r.max_drive       <= cfg_pwdata[MagW-1:0];
        REG_APPROACH_DRIVE:  cfg_r.approach_drive  <= cfg_pwdata[MagW-1:0];
        REG_APPR_WIN:        cfg_r.appr_win        <= cfg_pwdata[WideW-1:0];
        REG_TOLERANCE:       cfg_r.tolerance       <= cfg_pwdata[WideW-1:0];
        REG_BRAKE_LEN:       cfg_r.brake_len       <= cfg_pwdata[WideW-1:0];
        REG_USE_STARTER:     cfg_r.use_starter     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      REG_TURN_LEFT:       cfg_prdata = {31'd0, cfg_r.turn_left};
      REG_TARGET_TURN:     cfg_prdata = {16'd0, cfg_r.target_turn};
      REG_MAX_DRIVE:       cfg_prdata = {25'd0, cfg_r.max_drive};
      REG_APPROACH_DRIVE:  cfg_prdata = {25'd0, cfg_r.approach_drive};
      REG_APPR_WIN:        cfg_prdata = {16'd0, cfg_r.appr_win};
      REG_TOLERANCE:       cfg_prdata = {16'd0, cfg_r.tolerance};
      REG_BRAKE_LEN:       cfg_prdata = {16'd0, cfg_r.brake_len};
      REG_USE_STARTER:     cfg_prdata = {31'd0, cfg_r.use_starter};
      default:             cfg_prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/encoder_spin_turn_controller.sv
// an accepted input word passes through the input register, then the tick logic into
// the result register, which holds its result word
// throughput: 1 word per cycle while out_tready is high; the result register stalls
// the input register only when it is full and not taken
// reset: synchronous on rst_n low; phase goes to init, snapshots and brake state clear,
// configuration registers return to defaults (turn_left 1, all others 0)
module encoder_spin_turn_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  // left_count[31:0], right_count[63:32], start_pressed[64], zero fill [71:65]
  input  logic [est_pkg::InDataW-1:0] in_tdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // left_drive[7:0], right_drive[15:8], brake_on[16], stop_on[17],
  // correction_start[18], phase[20:19], turned[52:21], zero fill [55:53]
  output logic [est_pkg::OutDataW-1:0] out_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [est_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import est_pkg::*;

  cfg_t cfg;

  est_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  // input register
  logic              in_vld_r;
  logic [CountW-1:0] left_r, right_r;
  logic              start_r;

  // state
  phase_t            phase_r, phase_nxt;
  logic [CountW-1:0] snap_left_r, snap_left_nxt;
  logic [CountW-1:0] snap_right_r, snap_right_nxt;
  logic [WideW-1:0]  brake_left_r, brake_left_nxt;
  logic              braking_r, braking_nxt;

  // result register
  logic                     out_vld_r;
  logic signed [DriveW-1:0] ldrv_r, ldrv_nxt;
  logic signed [DriveW-1:0] rdrv_r, rdrv_nxt;
  logic                     brk_r, brk_nxt;
  logic                     stp_r, stp_nxt;
  logic                     cst_r, cst_nxt;
  phase_t                   oph_r;
  logic signed [CountW-1:0] turned_r, turned_nxt;

  logic adv, in_acc;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // tick arithmetic
  logic [CountW-1:0]        dl, dr, diff;
  logic signed [CountW-1:0] half, wturn;
  logic signed [RemW-1:0]   rem;
  logic [RemW-1:0]          mag;
  logic                     in_tol, in_win;
  logic [MagW-1:0]          pwr;
  logic signed [DriveW-1:0] pwr_s;
  logic                     td_pos;

  always_comb begin
    dl     = left_r - snap_left_r;
    dr     = right_r - snap_right_r;
    diff   = dr - dl;
    // arithmetic shift floors; bump odd negatives to truncate toward zero
    half   = ($signed(diff) >>> 1) + $signed({{(CountW-1){1'b0}}, diff[CountW-1] & diff[0]});
    wturn  = cfg.turn_left ? half : -half;
    rem    = $signed({{(RemW-WideW){1'b0}}, cfg.target_turn})
           - $signed({{(RemW-CountW){wturn[CountW-1]}}, wturn});
    mag    = rem[RemW-1] ? $unsigned(-rem) : $unsigned(rem);
    in_tol = mag <= {{(RemW-WideW){1'b0}}, cfg.tolerance};
    in_win = mag <= {{(RemW-WideW){1'b0}}, cfg.appr_win};
    pwr    = (in_win && (cfg.approach_drive < cfg.max_drive)) ? cfg.approach_drive
                                                               : cfg.max_drive;
    pwr_s  = $signed({1'b0, pwr});
    td_pos = ((rem > 0) == cfg.turn_left);
  end

  always_comb begin
    phase_nxt      = phase_r;
    snap_left_nxt  = snap_left_r;
    snap_right_nxt = snap_right_r;
    brake_left_nxt = brake_left_r;
    braking_nxt    = braking_r;
    ldrv_nxt       = '0;
    rdrv_nxt       = '0;
    brk_nxt        = 1'b0;
    stp_nxt        = 1'b0;
    cst_nxt        = 1'b0;
    turned_nxt     = '0;
    unique case (phase_r)
      PH_INIT: phase_nxt = PH_WAIT;
      PH_WAIT: begin
        if (!cfg.use_starter || start_r) begin
          snap_left_nxt  = left_r;
          snap_right_nxt = right_r;
          braking_nxt    = 1'b0;
          cst_nxt        = 1'b1;
          phase_nxt      = PH_TURN;
        end
      end
      PH_TURN: begin
        turned_nxt = wturn;
        if (braking_r) begin
          if (brake_left_r <= WideW'(1)) begin
            brake_left_nxt = '0;
            stp_nxt        = 1'b1;
            phase_nxt      = PH_DONE;
          end else begin
            brake_left_nxt = brake_left_r - WideW'(1);
            brk_nxt        = 1'b1;
          end
        end else if (in_tol) begin
          brk_nxt        = 1'b1;
          brake_left_nxt = cfg.brake_len;
          braking_nxt    = 1'b1;
        end else begin
          ldrv_nxt = td_pos ? -pwr_s : pwr_s;
          rdrv_nxt = td_pos ? pwr_s : -pwr_s;
        end
      end
      PH_DONE: turned_nxt = wturn;
      default: phase_nxt = PH_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      phase_r      <= PH_INIT;
      snap_left_r  <= '0;
      snap_right_r <= '0;
      brake_left_r <= '0;
      braking_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r    <= 1'b1;
        phase_r      <= phase_nxt;
        snap_left_r  <= snap_left_nxt;
        snap_right_r <= snap_right_nxt;
        brake_left_r <= brake_left_nxt;
        braking_r    <= braking_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_r  <= in_tdata[CountW-1:0];
      right_r <= in_tdata[2*CountW-1:CountW];
      start_r <= in_tdata[2*CountW];
    end
    if (adv) begin
      ldrv_r   <= ldrv_nxt;
      rdrv_r   <= rdrv_nxt;
      brk_r    <= brk_nxt;
      stp_r    <= stp_nxt;
      cst_r    <= cst_nxt;
      oph_r    <= phase_nxt;
      turned_r <= turned_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OutDataW-2*DriveW-5-CountW){1'b0}}, turned_r, oph_r,
                       cst_r, stp_r, brk_r, rdrv_r, ldrv_r};

`ifndef ASSERT_OFF
  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("left done phase without reset");

  a_brake_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
    braking_r |-> phase_r == PH_TURN || phase_r == PH_DONE)
    else $error("braking outside turn");

  a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_INIT && adv) |=> phase_r == PH_WAIT)
    else $error("init phase not left after one word");

  a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && cst_r) |-> (oph_r == PH_TURN && turned_r == '0))
    else $error("start word with wrong phase or turn");

  a_stop_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && stp_r) |-> (oph_r == PH_DONE && !brk_r))
    else $error("stop word inconsistent");
`endif

endmodule

FILE: test/tb.sv
module tb;
  import est_pkg::*;

  typedef struct packed {
    logic [6:0]        fill;
    logic              start_pressed;
    logic [CountW-1:0] right_count;
    logic [CountW-1:0] left_count;
  } tick_in_t;

  typedef struct packed {
    logic [2:0]        fill;
    logic [CountW-1:0] turned;
    logic [1:0]        phase;
    logic              correction_start;
    logic              stop_on;
    logic              brake_on;
    logic [DriveW-1:0] right_drive;
    logic [DriveW-1:0] left_drive;
  } tick_out_t;

  // register byte addresses
  typedef enum logic [AddrW-1:0] {
    A_TURN_LEFT   = 0,
    A_TARGET      = 4,
    A_MAX_DRIVE   = 8,
    A_APPR_DRIVE  = 12,
    A_APPR_WIN    = 16,
    A_TOLERANCE   = 20,
    A_BRAKE_LEN   = 24,
    A_USE_STARTER = 28
  } cfg_addr_t;

  localparam int IdlePct    = 10;
  localparam int StallLimit = 2000;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic [InDataW-1:0]  in_tdata    = '0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [AddrW-1:0]    cfg_paddr   = '0;
  logic [31:0]         cfg_pwdata  = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  tick_in_t  ticks[$];
  tick_out_t due_commands[$];
  cfg_t      knobs;

  // controller state as the block should hold it
  phase_t      ctl_phase;
  logic [31:0] ctl_snap_l, ctl_snap_r;
  logic [16:0] ctl_brake_left;
  logic        ctl_braking;

  // snapshot the stimulus plans around
  logic [31:0] spin_l, spin_r;

  int n_err       = 0;
  int n_sent      = 0;
  int n_results   = 0;
  int quiet_cycles = 0;

  encoder_spin_turn_controller i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // half the wheel delta difference, truncated toward zero, signed by direction
  function automatic logic signed [31:0] turn_of(logic [31:0] l, logic [31:0] r,
                                                 logic [31:0] sl, logic [31:0] sr,
                                                 logic left_dir);
    logic [31:0]        diff;
    logic signed [31:0] half;
    diff = (r - sr) - (l - sl);
    half = $signed(diff) / 2;
    return left_dir ? half : -half;
  endfunction

  function automatic tick_in_t mk_tick(logic [31:0] l, logic [31:0] r, logic pressed);
    tick_in_t t;
    t = '0;
    t.left_count    = l;
    t.right_count   = r;
    t.start_pressed = pressed;
    return t;
  endfunction

  // counts that leave the given remaining turn, with random common motion
  function automatic tick_in_t tick_for_rem(longint rem, bit keep_out);
    longint      tol, t, w, diff;
    logic [31:0] dl;
    tol = knobs.tolerance;
    if (keep_out && rem <= tol && rem >= -tol) rem = (rem < 0) ? -(tol + 1) : tol + 1;
    t = longint'(knobs.target_turn) - rem;
    w = knobs.turn_left ? t : -t;
    diff = 2 * w;
    // odd differences must truncate back to the same half
    if (w > 0) diff = diff + longint'($urandom_range(1));
    else if (w < 0) diff = diff - longint'($urandom_range(1));
    else diff = diff + longint'($urandom_range(2)) - 1;
    dl = $urandom;
    return mk_tick(spin_l + dl, spin_r + dl + diff[31:0], 1'($urandom));
  endfunction

  function automatic cfg_t random_knobs();
    cfg_t k;
    k.turn_left       = 1'($urandom);
    k.target_turn     = 16'($urandom);
    k.max_drive       = 7'($urandom);
    k.approach_drive  = 7'($urandom);
    k.appr_win        = ($urandom_range(1) == 1) ? 16'($urandom_range(2000)) : 16'($urandom);
    k.tolerance       = ($urandom_range(1) == 1) ? 16'($urandom_range(100)) : 16'($urandom);
    k.brake_len       = 16'($urandom);
    k.use_starter     = 1'($urandom);
    return k;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      n_err++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  task automatic cfg_write(cfg_addr_t addr, logic [31:0] val);
    logic [31:0] kept;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (addr)
      A_TURN_LEFT:   begin knobs.turn_left       = val[0];    kept = {31'd0, val[0]}; end
      A_TARGET:      begin knobs.target_turn     = val[15:0]; kept = {16'd0, val[15:0]}; end
      A_MAX_DRIVE:   begin knobs.max_drive       = val[6:0];  kept = {25'd0, val[6:0]}; end
      A_APPR_DRIVE:  begin knobs.approach_drive  = val[6:0];  kept = {25'd0, val[6:0]}; end
      A_APPR_WIN:    begin knobs.appr_win        = val[15:0]; kept = {16'd0, val[15:0]}; end
      A_TOLERANCE:   begin knobs.tolerance       = val[15:0]; kept = {16'd0, val[15:0]}; end
      A_BRAKE_LEN:   begin knobs.brake_len       = val[15:0]; kept = {16'd0, val[15:0]}; end
      A_USE_STARTER: begin knobs.use_starter     = val[0];    kept = {31'd0, val[0]}; end
      default:       kept = '0;
    endcase
    // read it back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== kept) begin
      n_err++;
      $error("register at %0d: expected %0h, got %0h", addr, kept, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apply_knobs(cfg_t k);
    cfg_write(A_TURN_LEFT,   {31'd0, k.turn_left});
    cfg_write(A_TARGET,      {16'd0, k.target_turn});
    cfg_write(A_MAX_DRIVE,   {25'd0, k.max_drive});
    cfg_write(A_APPR_DRIVE,  {25'd0, k.approach_drive});
    cfg_write(A_APPR_WIN,    {16'd0, k.appr_win});
    cfg_write(A_TOLERANCE,   {16'd0, k.tolerance});
    cfg_write(A_BRAKE_LEN,   {16'd0, k.brake_len});
    cfg_write(A_USE_STARTER, {31'd0, k.use_starter});
    @(negedge clk);
  endtask

  task automatic drain();
    do @(negedge clk); while (ticks.size() != 0 || due_commands.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    logic go;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        ticks.delete(0);
        n_sent++;
      end
      if (in_tvalid && !in_tready) go = 1'b1;
      else go = ticks.size() != 0 &&
                ((n_sent >= 300 && n_sent < 650) || $urandom_range(99) >= IdlePct);
      in_tvalid <= go;
      if (go) in_tdata <= ticks[0];
    end
  end

  // monitor: predicts each accepted word and checks each result word
  always @(posedge clk) begin
    tick_in_t           tk;
    tick_out_t          got, want;
    logic signed [31:0] trn;
    longint             rem, mag;
    int                 drive, steer, ld, rd;
    if (!rst_n) begin
      out_tready     <= 1'b0;
      ctl_phase      = PH_INIT;
      ctl_snap_l     = '0;
      ctl_snap_r     = '0;
      ctl_brake_left = '0;
      ctl_braking    = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        n_results++;
        if (due_commands.size() == 0) begin
          n_err++;
          $error("result word with no expectation waiting");
        end else begin
          want = due_commands.pop_front();
          check_field("left_drive", $signed(want.left_drive), $signed(got.left_drive));
          check_field("right_drive", $signed(want.right_drive), $signed(got.right_drive));
          check_field("brake_on", want.brake_on, got.brake_on);
          check_field("stop_on", want.stop_on, got.stop_on);
          check_field("correction_start", want.correction_start, got.correction_start);
          check_field("phase", want.phase, got.phase);
          check_field("turned", $signed(want.turned), $signed(got.turned));
          check_field("fill", want.fill, got.fill);
        end
      end
      if (in_tvalid && in_tready) begin
        tk   = in_tdata;
        want = '0;
        trn  = turn_of(tk.left_count, tk.right_count, ctl_snap_l, ctl_snap_r, knobs.turn_left);
        case (ctl_phase)
          PH_INIT: ctl_phase = PH_WAIT;
          PH_WAIT: begin
            if (!knobs.use_starter || tk.start_pressed) begin
              ctl_snap_l  = tk.left_count;
              ctl_snap_r  = tk.right_count;
              ctl_braking = 1'b0;
              want.correction_start = 1'b1;
              ctl_phase   = PH_TURN;
            end
          end
          PH_TURN: begin
            want.turned = trn;
            if (ctl_braking) begin
              if (ctl_brake_left <= 1) begin
                ctl_brake_left = '0;
                want.stop_on   = 1'b1;
                ctl_phase      = PH_DONE;
              end else begin
                ctl_brake_left = ctl_brake_left - 1'b1;
                want.brake_on  = 1'b1;
              end
            end else begin
              rem = longint'(knobs.target_turn) - longint'(trn);
              mag = rem < 0 ? -rem : rem;
              if (mag <= longint'(knobs.tolerance)) begin
                want.brake_on  = 1'b1;
                ctl_brake_left = {1'b0, knobs.brake_len};
                ctl_braking    = 1'b1;
              end else begin
                drive = int'(knobs.max_drive);
                if (mag <= longint'(knobs.appr_win) &&
                    int'(knobs.approach_drive) < drive)
                  drive = int'(knobs.approach_drive);
                // wheels spin opposite ways, toward the target
                steer = ((rem > 0) == knobs.turn_left) ? 1 : -1;
                ld = -steer * drive;
                rd = steer * drive;
                want.left_drive  = ld[7:0];
                want.right_drive = rd[7:0];
              end
            end
          end
          default: want.turned = trn;
        endcase
        want.phase = ctl_phase;
        due_commands.push_back(want);
      end
      out_tready <= (n_results >= 300 && n_results < 650) || $urandom_range(99) >= IdlePct;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    cfg_t        k;
    tick_in_t    tk;
    longint      rem, trn, tol;
    bit          by_press;
    knobs = '0;
    knobs.turn_left = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // init and waiting, starter armed, all knobs at their top
    k = '1;
    k.turn_left = 1'b0;
    apply_knobs(k);
    ticks.push_back(mk_tick(32'h0, 32'h0, 1'b0));
    ticks.push_back(mk_tick(32'hffff_ffff, 32'hffff_ffff, 1'b0));
    ticks.push_back(mk_tick(32'h8000_0000, 32'h7fff_ffff, 1'b0));
    ticks.push_back(mk_tick(32'h7fff_ffff, 32'h8000_0000, 1'b0));
    repeat (60) ticks.push_back(mk_tick($urandom, $urandom, 1'b0));
    drain();
    k = '0;
    k.turn_left   = 1'b1;
    k.use_starter = 1'b1;
    apply_knobs(k);
    repeat (60) ticks.push_back(mk_tick($urandom, $urandom, 1'b0));
    drain();

    // start either on a press or by dropping the starter
    by_press = 1'($urandom);
    k.turn_left       = 1'($urandom);
    k.target_turn     = 16'd1000;
    k.max_drive       = 7'd127;
    k.approach_drive  = 7'd30;
    k.appr_win        = 16'd200;
    k.tolerance       = 16'd5;
    k.brake_len       = 16'($urandom);
    k.use_starter     = by_press;
    apply_knobs(k);
    // snapshot next to the wrap points so deltas wrap
    spin_l = 32'h7fff_fff0;
    spin_r = 32'h8000_0005;
    ticks.push_back(mk_tick(spin_l, spin_r, by_press ? 1'b1 : 1'($urandom)));
    ticks.push_back(tick_for_rem(6, 1'b1));
    ticks.push_back(tick_for_rem(-6, 1'b1));
    ticks.push_back(tick_for_rem(200, 1'b1));
    ticks.push_back(tick_for_rem(201, 1'b1));
    ticks.push_back(tick_for_rem(-200, 1'b1));
    ticks.push_back(tick_for_rem(-201, 1'b1));
    ticks.push_back(tick_for_rem(longint'(1) << 29, 1'b1));
    ticks.push_back(tick_for_rem(-(longint'(1) << 29), 1'b1));
    ticks.push_back(mk_tick(spin_l, spin_r + 32'h8000_0000, 1'b1));
    ticks.push_back(mk_tick(spin_l, spin_r + 32'h7fff_ffff, 1'b0));
    ticks.push_back(mk_tick(spin_l + 32'd1, spin_r, 1'b1));
    ticks.push_back(mk_tick(spin_l + 32'd3, spin_r, 1'b0));
    ticks.push_back(mk_tick(spin_l, spin_r + 32'd3, 1'b1));

    // turning under changing knobs, kept outside the tolerance
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      k = random_knobs();
      if (ph == 0) begin
        k = '0;
      end else if (ph == 1) begin
        k = '1;
      end
      apply_knobs(k);
      tol = knobs.tolerance;
      repeat (100) begin
        if ($urandom_range(99) < 85) begin
          case ($urandom_range(4))
            0: rem = tol + 1;
            1: rem = longint'(knobs.appr_win);
            2: rem = longint'(knobs.appr_win) + 1;
            3: rem = longint'($urandom_range(600)) - 300;
            default: rem = longint'($urandom_range(32'h2000_0000));
          endcase
          if ($urandom_range(1) == 1) rem = -rem;
          ticks.push_back(tick_for_rem(rem, 1'b1));
        end else begin
          do begin
            tk  = mk_tick($urandom, $urandom, 1'($urandom));
            trn = turn_of(tk.left_count, tk.right_count, spin_l, spin_r, knobs.turn_left);
            rem = longint'(knobs.target_turn) - trn;
          end while (rem <= tol && rem >= -tol);
          ticks.push_back(tk);
        end
      end
    end

    // land inside the tolerance, then brake and stop
    drain();
    k = random_knobs();
    k.tolerance   = 16'($urandom_range(50));
    k.brake_len   = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(40, 1));
    apply_knobs(k);
    tol = knobs.tolerance;
    ticks.push_back(tick_for_rem(longint'($urandom_range(2 * tol)) - tol, 1'b0));
    repeat (int'(k.brake_len) + 4) ticks.push_back(mk_tick($urandom, $urandom, 1'($urandom)));

    // done for good, only turned moves
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      k = random_knobs();
      apply_knobs(k);
      if (ph == 0) begin
        ticks.push_back(mk_tick(32'h8000_0000, 32'h7fff_ffff, 1'b1));
        ticks.push_back(mk_tick(32'h7fff_ffff, 32'h8000_0000, 1'b0));
        ticks.push_back(mk_tick(32'h0, 32'hffff_ffff, 1'b1));
      end
      repeat (100) ticks.push_back(mk_tick($urandom, $urandom, 1'($urandom)));
    end

    drain();
    repeat (4) @(posedge clk);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/est_pkg.sv
hw/rtl/est_cfg.sv
hw/rtl/encoder_spin_turn_controller.sv
test/tb.sv
